>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the session controller
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

>>> rtl/core/uss_pkg.sv
// ----------------------------------------------------------------------------
// uss_pkg
// types, codes and reset values shared by the session controller files
// ----------------------------------------------------------------------------
package uss_pkg;

   localparam int NOW_BITS       = 32;
   localparam int TIME_BITS_DEF  = 32;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_IDX_BITS   = 3;

   // event codes on the request channel
   localparam logic [3:0] REQ_TICK       = 4'd0;
   localparam logic [3:0] REQ_CONNECT    = 4'd1;
   localparam logic [3:0] REQ_ACCEPT     = 4'd2;
   localparam logic [3:0] REQ_DISCONNECT = 4'd3;
   localparam logic [3:0] REQ_SYN_ACK    = 4'd4;
   localparam logic [3:0] REQ_ACK        = 4'd5;
   localparam logic [3:0] REQ_FIN        = 4'd6;
   localparam logic [3:0] REQ_HB         = 4'd7;
   localparam logic [3:0] REQ_HB_REPLY   = 4'd8;
   localparam logic [3:0] REQ_DATA       = 4'd9;

   // packet kinds
   localparam logic [2:0] SEND_NONE     = 3'd0;
   localparam logic [2:0] SEND_SYN      = 3'd1;
   localparam logic [2:0] SEND_SYN_ACK  = 3'd2;
   localparam logic [2:0] SEND_ACK      = 3'd3;
   localparam logic [2:0] SEND_FIN      = 3'd4;
   localparam logic [2:0] SEND_HB       = 3'd5;
   localparam logic [2:0] SEND_HB_REPLY = 3'd6;

   // user events
   localparam logic [3:0] EV_NONE          = 4'd0;
   localparam logic [3:0] EV_CONNECTED     = 4'd1;
   localparam logic [3:0] EV_REJECTED      = 4'd2;
   localparam logic [3:0] EV_TIMEOUT       = 4'd3;
   localparam logic [3:0] EV_ACCEPTED      = 4'd4;
   localparam logic [3:0] EV_ACCEPT_FAILED = 4'd5;
   localparam logic [3:0] EV_CLOSED        = 4'd6;
   localparam logic [3:0] EV_CLOSED_NOTIFY = 4'd7;
   localparam logic [3:0] EV_DELIVER       = 4'd8;

   // connection states
   localparam logic [2:0] ST_CLOSED      = 3'd0;
   localparam logic [2:0] ST_CONNECTING  = 3'd1;
   localparam logic [2:0] ST_SYN_RECV    = 3'd2;
   localparam logic [2:0] ST_ESTAB       = 3'd3;
   localparam logic [2:0] ST_FIN_PENDING = 3'd4;
   localparam logic [2:0] ST_CLOSE_WAIT  = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_ROLE        = 3'd0;
   localparam logic [2:0] CSR_CONNECT_TO  = 3'd1;
   localparam logic [2:0] CSR_ACCEPT_TO   = 3'd2;
   localparam logic [2:0] CSR_CLOSE_TO    = 3'd3;
   localparam logic [2:0] CSR_ACK_WINDOW  = 3'd4;
   localparam logic [2:0] CSR_HB_GAP      = 3'd5;
   localparam logic [2:0] CSR_LOSS_LIMIT  = 3'd6;
   localparam logic [2:0] CSR_PROBE_AFTER = 3'd7;

   localparam logic [3:0] LOSS_MAX = 4'd15;

   typedef struct packed {
      logic        role;
      logic [15:0] connect_timeout;
      logic [15:0] accept_timeout;
      logic [15:0] close_timeout;
      logic [15:0] ack_repeat_window;
      logic [15:0] heartbeat_gap;
      logic [3:0]  loss_limit;
      logic [3:0]  probe_after;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      role:              1'b0,
      connect_timeout:   16'd3000,
      accept_timeout:    16'd5000,
      close_timeout:     16'd1000,
      ack_repeat_window: 16'd2000,
      heartbeat_gap:     16'd6000,
      loss_limit:        4'd9,
      probe_after:       4'd2
   };

   typedef struct packed {
      logic [3:0]          req_type;
      logic [NOW_BITS-1:0] now_ms;
      logic [31:0]         value;
      logic [31:0]         conv_id;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  send_kind;
      logic [31:0] send_value;
      logic [31:0] send_conv;
      logic [3:0]  event_code;
      logic [2:0]  state_now;
      logic        last;
   } rsp_type;

   // one or two results of a single event
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } rsp_pair_type;

   function automatic rsp_type mk_rsp(logic [2:0] kind, logic [31:0] val,
                                      logic [31:0] conv, logic [3:0] ev);
      rsp_type r;
      r            = '0;
      r.send_kind  = kind;
      r.send_value = val;
      r.send_conv  = conv;
      r.event_code = ev;
      return r;
   endfunction

endpackage

>>> rtl/core/uss_req_if.sv
// ----------------------------------------------------------------------------
// uss_req_if
// event channel into the session controller
// ----------------------------------------------------------------------------
interface uss_req_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    req_type;
   logic [uss_pkg::NOW_BITS-1:0]  now_ms;
   logic [31:0]                   value;
   logic [31:0]                   conv_id;

   modport source (output valid, output req_type, output now_ms, output value,
                   output conv_id, input ready);
   modport sink   (input valid, input req_type, input now_ms, input value,
                   input conv_id, output ready);
endinterface

>>> rtl/core/uss_rsp_if.sv
// ----------------------------------------------------------------------------
// uss_rsp_if
// result channel out of the session controller
// ----------------------------------------------------------------------------
interface uss_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  send_kind;
   logic [31:0] send_value;
   logic [31:0] send_conv;
   logic [3:0]  event_code;
   logic [2:0]  state_now;
   logic        last;

   modport source (output valid, output send_kind, output send_value, output send_conv,
                   output event_code, output state_now, output last, input ready);
   modport sink   (input valid, input send_kind, input send_value, input send_conv,
                   input event_code, input state_now, input last, output ready);
endinterface

>>> rtl/core/udp_session_handshake_fsm.sv
// an accepted event waits in the input register, is decided there and is loaded
//   into the result register once it has room; its first result is then offered
// throughput: one event per cycle while each yields one result and the result
//   channel is ready; an event with two results holds the register for two transfers
// reset: synchronous, active high; session state back to closed, all stamps,
//   counts, nonce and id zero, registers back to their defaults
// ----------------------------------------------------------------------------
// udp_session_handshake_fsm
// handshake, timeout and heartbeat-loss controller for one udp session endpoint
// ----------------------------------------------------------------------------
module udp_session_handshake_fsm #(
   parameter int TIME_BITS = uss_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [uss_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [uss_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   uss_req_if.sink                            req_ch,
   uss_rsp_if.source                          rsp_ch
);

   // width of stamps and elapsed times; the timestamp is cut or zero-extended to it
   localparam int TW = TIME_BITS;

   // configuration registers
   uss_pkg::cfg_type cfg_ff;

   // input register
   uss_pkg::req_item_type in_ff;
   logic                  in_valid_ff, in_valid_in;
   logic                  req_xfer;
   logic                  advance;
   logic                  can_push;

   // session state
   logic [2:0]    conn_state_ff, conn_state_in;
   logic [TW-1:0] state_stamp_ff, state_stamp_in;
   logic [TW-1:0] last_rx_ff, last_rx_in;
   logic [3:0]    loss_count_ff, loss_count_in;
   logic [31:0]   nonce_ff, nonce_in;
   logic [31:0]   session_id_ff, session_id_in;

   // decision logic
   logic [TW-1:0]         now_tw;
   logic [TW-1:0]         since_state;
   logic [TW-1:0]         since_rx;
   logic [3:0]            loss_inc;
   logic                  notify;
   logic [2:0]            drop_state;
   uss_pkg::rsp_type      put_a, put_b;
   logic                  put_a_v, put_b_v;
   uss_pkg::rsp_pair_type pair;

   // ---------------------------------------------------------------------
   // configuration: plain write port, no read-back
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= uss_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            uss_pkg::CSR_ROLE:        cfg_ff.role              <= csr_wdata[0];
            uss_pkg::CSR_CONNECT_TO:  cfg_ff.connect_timeout   <= csr_wdata;
            uss_pkg::CSR_ACCEPT_TO:   cfg_ff.accept_timeout    <= csr_wdata;
            uss_pkg::CSR_CLOSE_TO:    cfg_ff.close_timeout     <= csr_wdata;
            uss_pkg::CSR_ACK_WINDOW:  cfg_ff.ack_repeat_window <= csr_wdata;
            uss_pkg::CSR_HB_GAP:      cfg_ff.heartbeat_gap     <= csr_wdata;
            uss_pkg::CSR_LOSS_LIMIT:  cfg_ff.loss_limit        <= csr_wdata[3:0];
            uss_pkg::CSR_PROBE_AFTER: cfg_ff.probe_after       <= csr_wdata[3:0];
            default:                  cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // input register: refilled in the same cycle it hands its event on
   // ---------------------------------------------------------------------
   assign advance      = in_valid_ff && can_push;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff.req_type <= req_ch.req_type;
         in_ff.now_ms   <= req_ch.now_ms;
         in_ff.value    <= req_ch.value;
         in_ff.conv_id  <= req_ch.conv_id;
      end
   end

   // ---------------------------------------------------------------------
   // elapsed times wrap modulo 2^TW
   // ---------------------------------------------------------------------
   assign now_tw      = TW'(in_ff.now_ms);
   assign since_state = now_tw - state_stamp_ff;
   assign since_rx    = now_tw - last_rx_ff;
   assign loss_inc    = (loss_count_ff == uss_pkg::LOSS_MAX) ? uss_pkg::LOSS_MAX
                                                             : loss_count_ff + 4'd1;
   // forced close tells the user the peer went quiet only on the side that sent fin
   assign notify      = (!cfg_ff.role && conn_state_ff == uss_pkg::ST_FIN_PENDING) ||
                        (cfg_ff.role && conn_state_ff == uss_pkg::ST_CLOSE_WAIT);
   assign drop_state  = cfg_ff.role ? uss_pkg::ST_CLOSE_WAIT : uss_pkg::ST_FIN_PENDING;

   // ---------------------------------------------------------------------
   // event decision: put_a is the main response, put_b the heartbeat one
   // ---------------------------------------------------------------------
   always_comb begin
      conn_state_in  = conn_state_ff;
      state_stamp_in = state_stamp_ff;
      last_rx_in     = last_rx_ff;
      loss_count_in  = loss_count_ff;
      nonce_in       = nonce_ff;
      session_id_in  = session_id_ff;
      put_a          = '0;
      put_a_v        = 1'b0;
      put_b          = '0;
      put_b_v        = 1'b0;

      case (in_ff.req_type) inside
         uss_pkg::REQ_TICK: begin
            unique case (conn_state_ff) inside
               uss_pkg::ST_CONNECTING: begin
                  put_a_v = 1'b1;
                  if (since_state > TW'(cfg_ff.connect_timeout)) begin
                     nonce_in       = '0;
                     session_id_in  = '0;
                     conn_state_in  = uss_pkg::ST_CLOSED;
                     state_stamp_in = now_tw;
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0, uss_pkg::EV_TIMEOUT);
                  end else begin
                     // syn retransmit
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_SYN, nonce_ff, '0, uss_pkg::EV_NONE);
                  end
               end
               uss_pkg::ST_SYN_RECV: begin
                  put_a_v = 1'b1;
                  if (since_state > TW'(cfg_ff.accept_timeout)) begin
                     nonce_in       = '0;
                     session_id_in  = '0;
                     conn_state_in  = uss_pkg::ST_CLOSED;
                     state_stamp_in = now_tw;
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0,
                                             uss_pkg::EV_ACCEPT_FAILED);
                  end else begin
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_SYN_ACK, nonce_ff, session_id_ff,
                                             uss_pkg::EV_NONE);
                  end
               end
               uss_pkg::ST_ESTAB: begin
                  // client repeats its ack for a while in case it was lost
                  if (!cfg_ff.role && since_state < TW'(cfg_ff.ack_repeat_window)) begin
                     put_a_v = 1'b1;
                     put_a   = uss_pkg::mk_rsp(uss_pkg::SEND_ACK, session_id_ff + 32'd1, '0,
                                               uss_pkg::EV_NONE);
                  end
                  // receive silence counts as one heartbeat loss
                  if (since_rx > TW'(cfg_ff.heartbeat_gap)) begin
                     loss_count_in = loss_inc;
                     last_rx_in    = now_tw;
                     if (loss_inc > cfg_ff.loss_limit) begin
                        if (session_id_ff != '0) begin
                           put_b_v        = 1'b1;
                           put_b          = uss_pkg::mk_rsp(uss_pkg::SEND_FIN, session_id_ff,
                                                            '0, uss_pkg::EV_NONE);
                           conn_state_in  = drop_state;
                           state_stamp_in = now_tw;
                        end
                     end else if (loss_inc >= cfg_ff.probe_after) begin
                        put_b_v = 1'b1;
                        put_b   = uss_pkg::mk_rsp(uss_pkg::SEND_HB, '0, '0, uss_pkg::EV_NONE);
                     end
                  end
               end
               uss_pkg::ST_FIN_PENDING, uss_pkg::ST_CLOSE_WAIT: begin
                  put_a_v = 1'b1;
                  if (since_state > TW'(cfg_ff.close_timeout)) begin
                     nonce_in       = '0;
                     session_id_in  = '0;
                     conn_state_in  = uss_pkg::ST_CLOSED;
                     state_stamp_in = now_tw;
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0,
                        notify ? uss_pkg::EV_CLOSED_NOTIFY : uss_pkg::EV_CLOSED);
                  end else begin
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_FIN, session_id_ff, '0,
                                             uss_pkg::EV_NONE);
                  end
               end
               default: begin
                  // idle tick drops leftovers of an aborted handshake
                  nonce_in       = '0;
                  session_id_in  = '0;
                  conn_state_in  = uss_pkg::ST_CLOSED;
                  state_stamp_in = now_tw;
               end
            endcase
         end

         uss_pkg::REQ_CONNECT: begin
            if (conn_state_ff == uss_pkg::ST_CLOSED) begin
               conn_state_in  = uss_pkg::ST_CONNECTING;
               state_stamp_in = now_tw;
               nonce_in       = in_ff.value;
               put_a_v        = 1'b1;
               put_a = uss_pkg::mk_rsp(uss_pkg::SEND_SYN, in_ff.value, '0, uss_pkg::EV_NONE);
            end
         end

         uss_pkg::REQ_ACCEPT: begin
            if (conn_state_ff == uss_pkg::ST_CLOSED && in_ff.value != '0) begin
               session_id_in  = in_ff.conv_id;
               conn_state_in  = uss_pkg::ST_SYN_RECV;
               state_stamp_in = now_tw;
               nonce_in       = in_ff.value + 32'd1;
               put_a_v        = 1'b1;
               put_a = uss_pkg::mk_rsp(uss_pkg::SEND_SYN_ACK, in_ff.value + 32'd1,
                                       in_ff.conv_id, uss_pkg::EV_NONE);
            end
         end

         uss_pkg::REQ_DISCONNECT: begin
            if (session_id_ff != '0) begin
               if (conn_state_ff == uss_pkg::ST_ESTAB) begin
                  put_a_v        = 1'b1;
                  put_a = uss_pkg::mk_rsp(uss_pkg::SEND_FIN, session_id_ff, '0,
                                          uss_pkg::EV_NONE);
                  conn_state_in  = drop_state;
                  state_stamp_in = now_tw;
               end else if (conn_state_ff == uss_pkg::ST_SYN_RECV ||
                            conn_state_ff == uss_pkg::ST_CONNECTING) begin
                  // silent abort, nonce and id stay until the next tick
                  conn_state_in  = uss_pkg::ST_CLOSED;
                  state_stamp_in = now_tw;
               end
            end
         end

         uss_pkg::REQ_SYN_ACK: begin
            if (!cfg_ff.role && conn_state_ff == uss_pkg::ST_CONNECTING) begin
               put_a_v        = 1'b1;
               state_stamp_in = now_tw;
               if (in_ff.value == nonce_ff + 32'd1) begin
                  session_id_in = in_ff.conv_id;
                  conn_state_in = uss_pkg::ST_ESTAB;
                  last_rx_in    = now_tw;
                  loss_count_in = '0;
                  put_a = uss_pkg::mk_rsp(uss_pkg::SEND_ACK, in_ff.conv_id + 32'd1, '0,
                                          uss_pkg::EV_CONNECTED);
               end else begin
                  nonce_in      = '0;
                  session_id_in = '0;
                  conn_state_in = uss_pkg::ST_CLOSED;
                  put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0, uss_pkg::EV_REJECTED);
               end
            end
         end

         uss_pkg::REQ_ACK: begin
            if (cfg_ff.role && conn_state_ff == uss_pkg::ST_SYN_RECV) begin
               put_a_v        = 1'b1;
               state_stamp_in = now_tw;
               if (session_id_ff == in_ff.value - 32'd1) begin
                  conn_state_in = uss_pkg::ST_ESTAB;
                  last_rx_in    = now_tw;
                  loss_count_in = '0;
                  put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0, uss_pkg::EV_ACCEPTED);
               end else begin
                  nonce_in      = '0;
                  session_id_in = '0;
                  conn_state_in = uss_pkg::ST_CLOSED;
                  put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0,
                                          uss_pkg::EV_ACCEPT_FAILED);
               end
            end
         end

         uss_pkg::REQ_FIN: begin
            if (in_ff.conv_id == session_id_ff) begin
               if (conn_state_ff == uss_pkg::ST_ESTAB) begin
                  // peer close answered like a local disconnect
                  if (session_id_ff != '0) begin
                     put_a_v        = 1'b1;
                     put_a = uss_pkg::mk_rsp(uss_pkg::SEND_FIN, session_id_ff, '0,
                                             uss_pkg::EV_NONE);
                     conn_state_in  = drop_state;
                     state_stamp_in = now_tw;
                  end
               end else if (conn_state_ff == uss_pkg::ST_FIN_PENDING ||
                            conn_state_ff == uss_pkg::ST_CLOSE_WAIT) begin
                  nonce_in       = '0;
                  session_id_in  = '0;
                  conn_state_in  = uss_pkg::ST_CLOSED;
                  state_stamp_in = now_tw;
                  put_a_v        = 1'b1;
                  put_a = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0,
                     notify ? uss_pkg::EV_CLOSED_NOTIFY : uss_pkg::EV_CLOSED);
               end
            end
         end

         uss_pkg::REQ_HB, uss_pkg::REQ_HB_REPLY, uss_pkg::REQ_DATA: begin
            if (conn_state_ff == uss_pkg::ST_ESTAB) begin
               last_rx_in    = now_tw;
               loss_count_in = '0;
               if (in_ff.req_type == uss_pkg::REQ_HB) begin
                  put_a_v = 1'b1;
                  put_a   = uss_pkg::mk_rsp(uss_pkg::SEND_HB_REPLY, '0, '0,
                                            uss_pkg::EV_NONE);
               end else if (in_ff.req_type == uss_pkg::REQ_DATA) begin
                  put_a_v = 1'b1;
                  put_a   = uss_pkg::mk_rsp(uss_pkg::SEND_NONE, '0, '0,
                                            uss_pkg::EV_DELIVER);
               end
            end
         end

         default: begin
            // unknown event codes leave everything as it is
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // pack results in order; an event with nothing to say still gives one
   // ---------------------------------------------------------------------
   always_comb begin
      pair = '0;
      if (put_a_v && put_b_v) begin
         pair.two    = 1'b1;
         pair.first  = put_a;
         pair.second = put_b;
      end else if (put_a_v) begin
         pair.first  = put_a;
      end else if (put_b_v) begin
         pair.first  = put_b;
      end
      pair.first.state_now  = conn_state_in;
      pair.second.state_now = conn_state_in;
      pair.first.last       = !pair.two;
      pair.second.last      = 1'b1;
   end

   // ---------------------------------------------------------------------
   // session registers move only when the event is handed on
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         conn_state_ff  <= uss_pkg::ST_CLOSED;
         state_stamp_ff <= '0;
         last_rx_ff     <= '0;
         loss_count_ff  <= '0;
         nonce_ff       <= '0;
         session_id_ff  <= '0;
      end else if (advance) begin
         conn_state_ff  <= conn_state_in;
         state_stamp_ff <= state_stamp_in;
         last_rx_ff     <= last_rx_in;
         loss_count_ff  <= loss_count_in;
         nonce_ff       <= nonce_in;
         session_id_ff  <= session_id_in;
      end
   end

   // result register with room for both results of one event
   uss_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (advance),
      .pair     (pair),
      .can_push (can_push),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> rtl/core/uss_rsp_buf.sv
// ----------------------------------------------------------------------------
// uss_rsp_buf
// two-slot result register: takes one or two results per event, drains in order
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uss_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  uss_pkg::rsp_pair_type pair,
   output logic                  can_push,
   uss_rsp_if.source             rsp_ch
);

   uss_pkg::rsp_type head_ff, head_in;
   uss_pkg::rsp_type tail_ff, tail_in;
   logic             head_valid_ff, head_valid_in;
   logic             tail_valid_ff, tail_valid_in;
   logic             pop;

   assign pop      = head_valid_ff && rsp_ch.ready;
   // free, or about to hand over its only result
   assign can_push = !head_valid_ff || (!tail_valid_ff && pop);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (push) begin
         head_in       = pair.first;
         tail_in       = pair.second;
         head_valid_in = 1'b1;
         tail_valid_in = pair.two;
      end else if (pop) begin
         head_in       = tail_ff;
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_ch.valid      = head_valid_ff;
   assign rsp_ch.send_kind  = head_ff.send_kind;
   assign rsp_ch.send_value = head_ff.send_value;
   assign rsp_ch.send_conv  = head_ff.send_conv;
   assign rsp_ch.event_code = head_ff.event_code;
   assign rsp_ch.state_now  = head_ff.state_now;
   assign rsp_ch.last       = head_ff.last;

   `ASSERT_IMPLIES(a_tail_needs_head, clock, reset, tail_valid_ff, head_valid_ff)
   `ASSERT_IMPLIES(a_first_of_two_not_last, clock, reset,
                   head_valid_ff && tail_valid_ff, !head_ff.last)
   `ASSERT_NEXT(a_second_follows, clock, reset,
                pop && tail_valid_ff && !push, head_valid_ff && head_ff.last)

endmodule
